/* rtl/core/nlp_pkg.sv */
// ----------------------------------------------------------------------------
// nlp_pkg
// Shared types for the next lexicographic permutation core.
// ----------------------------------------------------------------------------
`default_nettype none

package nlp_pkg;

  localparam int unsigned ELEM_W = 32;

  typedef logic signed [ELEM_W-1:0] elem_t;

endpackage

`default_nettype wire

/* rtl/core/nlp_order_unit.sv */
// ----------------------------------------------------------------------------
// nlp_order_unit
// Shared signed compare unit: flags when operand a is strictly below b.
// ----------------------------------------------------------------------------
`default_nettype none

module nlp_order_unit (
  input  wire nlp_pkg::elem_t a,
  input  wire nlp_pkg::elem_t b,
  output logic                less
);

  assign less = (a < b);

endmodule

`default_nettype wire

/* rtl/core/next_lexicographic_permutation_core.sv */
// ----------------------------------------------------------------------------
// next_lexicographic_permutation_core
// Collects a sequence of signed values and emits its next permutation.
// ----------------------------------------------------------------------------
// Elements are loaded one per cycle into a buffer memory until a transaction
// with is_last set closes the sequence (values beyond MAX_LEN are dropped).
// The core then scans from the tail for the pivot, looks for the rightmost
// greater element and streams the result, holding each one while out_stall
// is high. The swap sits in the output selection and the suffix reversal in
// the read order of the emission. The scans step one element at a time, set
// by the buffer's single read port and the one shared signed comparator.
// While a sequence is being processed in_stall is held high. When no larger
// permutation exists the ascending order is emitted with wrapped set.
`default_nettype none

module next_lexicographic_permutation_core #(
  parameter int unsigned MAX_LEN = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire nlp_pkg::elem_t element,
  input  wire logic           is_last,
  output logic                out_valid,
  input  wire logic           out_stall,
  output nlp_pkg::elem_t      out_element,
  output logic                out_last,
  output logic                wrapped
);

  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CW = $clog2(MAX_LEN + 1);

  typedef enum logic [8:0] {
    ST_LOAD      = 9'b000000001,
    ST_TAIL      = 9'b000000010,
    ST_RIGHT     = 9'b000000100,
    ST_SCAN      = 9'b000001000,
    ST_JRD       = 9'b000010000,
    ST_JSCAN     = 9'b000100000,
    ST_EMIT_RD   = 9'b001000000,
    ST_EMIT_LD   = 9'b010000000,
    ST_EMIT_HOLD = 9'b100000000
  } state_t;

  state_t         state;
  logic [CW-1:0]  count;
  logic [AW-1:0]  p;
  logic [AW-1:0]  j;
  logic [AW-1:0]  k;
  logic [AW-1:0]  pidx;
  nlp_pkg::elem_t right;
  nlp_pkg::elem_t pivot;
  nlp_pkg::elem_t partner;
  logic           wrap;

  nlp_pkg::elem_t mem [MAX_LEN];
  nlp_pkg::elem_t rd_data;
  logic [AW-1:0]  rd_addr;

  logic           in_take;
  logic           room;
  logic [CW-1:0]  n_new;
  logic [AW-1:0]  last_idx;
  logic [AW-1:0]  emit_addr;
  logic [AW-1:0]  emit_addr_next;

  nlp_pkg::elem_t cmp_a;
  nlp_pkg::elem_t cmp_b;
  logic           cmp_less;

  // result position k maps to buffer address: prefix as is, suffix reversed
  function automatic logic [AW-1:0] map_addr(
    input logic [AW-1:0] kk,
    input logic [AW-1:0] pp,
    input logic [CW-1:0] nn
  );
    logic [CW:0] sum;
    sum = '0;
    if (kk < pp) begin
      sum = {{(CW+1-AW){1'b0}}, kk};
    end else begin
      sum = {{(CW+1-AW){1'b0}}, pp} + {1'b0, nn} - (CW+1)'(1)
            - {{(CW+1-AW){1'b0}}, kk};
    end
    return sum[AW-1:0];
  endfunction

  assign in_stall = (state != ST_LOAD);
  assign in_take  = in_valid && !in_stall;
  assign room     = (count < CW'(MAX_LEN));
  assign n_new    = room ? (count + CW'(1)) : count;
  assign last_idx = AW'(count - CW'(1));

  assign emit_addr      = map_addr(k, p, count);
  assign emit_addr_next = map_addr(k + AW'(1), p, count);

  nlp_order_unit u_order (
    .a    (cmp_a),
    .b    (cmp_b),
    .less (cmp_less)
  );

  always_comb begin
    if (state == ST_JSCAN) begin
      cmp_a = pivot;
      cmp_b = rd_data;
    end else begin
      cmp_a = rd_data;
      cmp_b = right;
    end
  end

  always_comb begin
    rd_addr = '0;
    case (state)
      ST_TAIL:      rd_addr = last_idx;
      ST_RIGHT:     rd_addr = p - AW'(1);
      ST_SCAN:      rd_addr = p - AW'(2);
      ST_JRD:       rd_addr = j;
      ST_JSCAN:     rd_addr = j - AW'(1);
      ST_EMIT_RD:   rd_addr = emit_addr;
      ST_EMIT_HOLD: rd_addr = emit_addr_next;
      default:      rd_addr = '0;
    endcase
  end

  // buffer memory
  always_ff @(posedge clk) begin
    if (in_take && room) begin
      mem[count[AW-1:0]] <= element;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (in_take) begin
            count <= n_new;
            if (is_last) begin
              p     <= AW'(n_new - CW'(1));
              state <= ST_TAIL;
            end
          end
        end
        ST_TAIL: begin
          state <= ST_RIGHT;
        end
        ST_RIGHT: begin
          right <= rd_data;
          if (p == '0) begin
            wrap  <= 1'b1;
            k     <= '0;
            state <= ST_EMIT_RD;
          end else begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (cmp_less) begin
            pivot <= rd_data;
            pidx  <= p - AW'(1);
            j     <= last_idx;
            state <= ST_JRD;
          end else begin
            right <= rd_data;
            p     <= p - AW'(1);
            if (p == AW'(1)) begin
              wrap  <= 1'b1;
              k     <= '0;
              state <= ST_EMIT_RD;
            end
          end
        end
        ST_JRD: begin
          state <= ST_JSCAN;
        end
        ST_JSCAN: begin
          if (cmp_less) begin
            partner <= rd_data;
            wrap    <= 1'b0;
            k       <= '0;
            state   <= ST_EMIT_RD;
          end else begin
            j <= j - AW'(1);
          end
        end
        ST_EMIT_RD: begin
          state <= ST_EMIT_LD;
        end
        ST_EMIT_LD: begin
          if (!wrap && emit_addr == pidx) begin
            out_element <= partner;
          end else if (!wrap && emit_addr == j) begin
            out_element <= pivot;
          end else begin
            out_element <= rd_data;
          end
          out_last  <= (k == last_idx);
          wrapped   <= wrap;
          out_valid <= 1'b1;
          state     <= ST_EMIT_HOLD;
        end
        ST_EMIT_HOLD: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (out_last) begin
              count <= '0;
              state <= ST_LOAD;
            end else begin
              k     <= k + AW'(1);
              state <= ST_EMIT_LD;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* sim/nlp_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nlp_checker
// Predicts and checks the output of next_lexicographic_permutation_core.
// ----------------------------------------------------------------------------
// Watches both channels. Each accepted input transaction, up to MAX_LEN, goes
// into a private copy of the sequence. The closing transaction triggers the
// next permutation, and every result goes into a queue. Each accepted output
// transaction is compared field by field with the oldest queued result.
// ----------------------------------------------------------------------------

module nlp_checker #(
  parameter int unsigned MAX_LEN = 16
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  wire logic      in_stall,
  input  nlp_pkg::elem_t element,
  input  wire logic      is_last,
  input  wire logic      out_valid,
  input  wire logic      out_stall,
  input  nlp_pkg::elem_t out_element,
  input  wire logic      out_last,
  input  wire logic      wrapped,
  output int             fail_count,
  output int             expected_left,
  output int             seq_count,
  output int             wrap_count,
  output int             result_count
);

  typedef struct packed {
    nlp_pkg::elem_t value;
    logic           last;
    logic           wrap;
  } perm_result_t;

  nlp_pkg::elem_t seq_buf [MAX_LEN];
  int             stored;
  perm_result_t   perm_queue [$];

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fail_count++;
  endtask

  task automatic reverse_span(input int lo, input int hi);
    nlp_pkg::elem_t tmp;
    while (lo < hi) begin
      tmp         = seq_buf[lo];
      seq_buf[lo] = seq_buf[hi];
      seq_buf[hi] = tmp;
      lo++;
      hi--;
    end
  endtask

  // rearranges seq_buf[0..stored-1] in place
  task automatic next_permutation(output bit wrap);
    int             p;
    int             j;
    nlp_pkg::elem_t tmp;
    wrap = 1'b1;
    if (stored >= 2) begin
      p = stored - 1;
      while (p > 0 && !(seq_buf[p-1] < seq_buf[p]))
        p--;
      if (p == 0) begin
        reverse_span(0, stored - 1);
      end else begin
        j = stored - 1;
        while (!(seq_buf[p-1] < seq_buf[j]))
          j--;
        tmp          = seq_buf[p-1];
        seq_buf[p-1] = seq_buf[j];
        seq_buf[j]   = tmp;
        reverse_span(p, stored - 1);
        wrap = 1'b0;
      end
    end
  endtask

  task automatic take_element(input nlp_pkg::elem_t value, input logic closing);
    bit           wrap;
    perm_result_t r;
    int           k;
    if (stored < MAX_LEN) begin
      seq_buf[stored] = value;
      stored++;
    end
    if (closing) begin
      next_permutation(wrap);
      for (k = 0; k < stored; k++) begin
        r.value = seq_buf[k];
        r.last  = (k == stored - 1);
        r.wrap  = wrap;
        perm_queue.push_back(r);
      end
      stored = 0;
      seq_count++;
      if (wrap)
        wrap_count++;
    end
  endtask

  task automatic check_result();
    perm_result_t want;
    if (perm_queue.size() == 0) begin
      report_mismatch($sformatf("unexpected result transaction, element %0d", out_element));
    end else begin
      want = perm_queue.pop_front();
      if (out_element !== want.value)
        report_mismatch($sformatf("result %0d: element %0d, expected %0d",
                                  result_count, out_element, want.value));
      if (out_last !== want.last)
        report_mismatch($sformatf("result %0d: last flag %b, expected %b",
                                  result_count, out_last, want.last));
      if (wrapped !== want.wrap)
        report_mismatch($sformatf("result %0d: wrap flag %b, expected %b",
                                  result_count, wrapped, want.wrap));
    end
    result_count++;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall)
        check_result();
      if (in_valid && !in_stall)
        take_element(element, is_last);
      expected_left <= perm_queue.size();
    end
  end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for next_lexicographic_permutation_core.
// ----------------------------------------------------------------------------
// Sends directed sequences (single element, extremes, equal values, buffer
// overflow) and then random sequences of mixed length and value spread, with
// random idle gaps on the input and random stalls on the output. Checking is
// done by nlp_checker; this module only drives stimulus and gives the verdict.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int unsigned    SEQ_MAX      = 16;
  localparam int             TARGET_ITEMS = 230;
  localparam nlp_pkg::elem_t ELEM_MIN     = 32'sh8000_0000;
  localparam nlp_pkg::elem_t ELEM_MAX     = 32'sh7fff_ffff;

  logic           clk       = 1'b0;
  logic           rst       = 1'b1;
  logic           in_valid  = 1'b0;
  nlp_pkg::elem_t element   = '0;
  logic           is_last   = 1'b0;
  logic           out_stall = 1'b0;
  logic           in_stall;
  logic           out_valid;
  nlp_pkg::elem_t out_element;
  logic           out_last;
  logic           wrapped;

  int fail_count;
  int expected_left;
  int seq_count;
  int wrap_count;
  int result_count;
  int sent_count = 0;
  bit quiet      = 1'b0;

  always #4 clk = ~clk;

  next_lexicographic_permutation_core #(
    .MAX_LEN(SEQ_MAX)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .element(element),
    .is_last(is_last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_element(out_element),
    .out_last(out_last),
    .wrapped(wrapped)
  );

  nlp_checker #(
    .MAX_LEN(SEQ_MAX)
  ) chk (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .element(element),
    .is_last(is_last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_element(out_element),
    .out_last(out_last),
    .wrapped(wrapped),
    .fail_count(fail_count),
    .expected_left(expected_left),
    .seq_count(seq_count),
    .wrap_count(wrap_count),
    .result_count(result_count)
  );

  // mostly short gaps, a few long ones, none in quiet stretches
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55)
      return 0;
    else if (r < 90)
      return $urandom_range(1, 3);
    else
      return $urandom_range(8, 40);
  endfunction

  // 0: full range, 1: narrow band with many repeats, 2: extremes, 3: mixed
  function automatic nlp_pkg::elem_t pick_value(input int style);
    int s;
    s = (style == 3) ? $urandom_range(0, 2) : style;
    case (s)
      0: return nlp_pkg::elem_t'($urandom);
      1: return nlp_pkg::elem_t'($urandom_range(0, 4)) - 2;
      default: begin
        case ($urandom_range(0, 4))
          0: return ELEM_MIN;
          1: return ELEM_MAX;
          2: return -1;
          3: return 0;
          default: return 1;
        endcase
      end
    endcase
  endfunction

  task automatic send_element(input nlp_pkg::elem_t value, input logic closing);
    int gap;
    gap = idle_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    element  <= value;
    is_last  <= closing;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    sent_count++;
  endtask

  task automatic send_sequence(input int len, input int style);
    int k;
    for (k = 0; k < len; k++)
      send_element(pick_value(style), k == len - 1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_left != 0)
      @(posedge clk);
  endtask

  initial begin : sink_stall
    int stall_len;
    forever begin
      repeat ($urandom_range(1, 12)) @(posedge clk);
      stall_len = quiet ? 0 : idle_length();
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    #(4_000_000);
    $display("next_lexicographic_permutation_core verification failed");
    $finish;
  end

  initial begin : stimulus
    int r;
    int len;
    int k;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // single element
    send_element(ELEM_MIN, 1'b1);
    // extremes in both orders
    send_element(ELEM_MIN, 1'b0);
    send_element(ELEM_MAX, 1'b1);
    send_element(ELEM_MAX, 1'b0);
    send_element(ELEM_MIN, 1'b1);
    // equal values around the pivot and the swap partner
    send_element(1, 1'b0);
    send_element(3, 1'b0);
    send_element(3, 1'b1);
    // overflow, closing transaction dropped
    for (k = 0; k < SEQ_MAX + 1; k++)
      send_element(pick_value(3), k == SEQ_MAX);
    wait_drained();

    while (sent_count < TARGET_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 70)
        len = $urandom_range(1, 6);
      else if (r < 93)
        len = $urandom_range(7, SEQ_MAX);
      else
        len = $urandom_range(SEQ_MAX + 1, SEQ_MAX + 4);
      if ($urandom_range(0, 9) == 0)
        quiet = ~quiet;
      send_sequence(len, $urandom_range(0, 3));
      if ($urandom_range(0, 7) == 0)
        wait_drained();
    end

    wait_drained();
    repeat (40) @(posedge clk);
    $display("stimulus: %0d input transactions in %0d sequences, %0d with no larger order",
             sent_count, seq_count, wrap_count);
    $display("checked %0d result transactions field by field", result_count);
    if (fail_count == 0 && expected_left == 0)
      $display("next_lexicographic_permutation_core verification clean");
    else
      $display("next_lexicographic_permutation_core verification failed");
    $finish;
  end

endmodule
